[rtl/tgr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tile grid collision package
// Shared widths, codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package tgr_pkg;

   localparam int POS_W      = 16;  // pixel or cell position
   localparam int SIZE_W     = 15;  // rectangle size
   localparam int TILE_W     = 16;  // tile id on the ports
   localparam int CDIM_W     = 11;  // cell size in pixels
   localparam int MAP_W      = 7;   // map size in cells
   localparam int DVD_W      = 18;  // signed dividend and quotient
   localparam int CELL_W     = 19;  // signed cell coordinate after offset
   localparam int NCNT_W     = 17;  // vertex count along one axis
   localparam int PROD_W     = 2 * NCNT_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_READ  = 2'd1,
      MODE_FAST  = 2'd2,
      MODE_FULL  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELL_WIDTH  = 3'd0,
      CSR_CELL_HEIGHT = 3'd1,
      CSR_OFFSET_X    = 3'd2,
      CSR_OFFSET_Y    = 3'd3,
      CSR_MAP_WIDTH   = 3'd4,
      CSR_MAP_HEIGHT  = 3'd5
   } csr_index_type;

   // Operand pair fed to the shared divider, and where its quotient lands.
   typedef enum logic [2:0] {
      DIV_X1 = 3'd0,
      DIV_Y1 = 3'd1,
      DIV_X2 = 3'd2,
      DIV_Y2 = 3'd3,
      DIV_NX = 3'd4,
      DIV_NY = 3'd5,
      DIV_PX = 3'd6,
      DIV_PY = 3'd7
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        addr_corner;
      logic [1:0]  corner;
      logic        wr_cell;
      logic        clear_wr;
      logic        row_init;
      logic        row_next;
      logic        col_init;
      logic        col_next;
      logic        mul;
      logic        finish;
      logic        res_hit;
      logic        res_ovf;
      logic        res_rd;
   } tgr_cmd_type;

   typedef struct packed {
      logic div_done;
      logic in_bounds;
      logic fast_ok;
      logic rd_nonzero;
      logic clear_last;
      logic vert_ovf;
      logic row_end;
      logic col_end;
   } tgr_sts_type;

   // True when a signed cell coordinate lies in [0, lim).
   function automatic logic in_span(logic signed [CELL_W-1:0] c, logic [MAP_W-1:0] lim);
      logic [CELL_W-2:0] lim_ext;
      lim_ext = {{(CELL_W-1-MAP_W){1'b0}}, lim};
      return !c[CELL_W-1] && (c[CELL_W-2:0] < lim_ext);
   endfunction

endpackage
`default_nettype wire

[rtl/tile_grid_rect_collision.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tile grid rectangle collision
// Tile map storage with cell write, cell read, corner collision and full
// vertex-walk collision of a pixel rectangle.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, and exactly one
// response follows: rsp_valid is high for a single cycle and the receiver must
// capture the fields then, because the block never waits for it. After reset
// the block sweeps all MAX_WIDTH*MAX_HEIGHT cells (4096 by default) of the
// tile memory to zero, one cell per cycle, with busy high; configuration
// writes are taken at any time and csr_ready is always high, but should only
// be issued while busy is low. One transaction is in flight at a time. Pixel
// to cell conversion uses a shared restoring divider. A cell write or read
// needs no divide, a corner collision divides four times before it reads the
// corners, and a full collision first derives the vertex counts, checks them
// against the vertex budget and then walks the grid row by row and vertex by
// vertex, stopping at the first occupied cell. The response is registered and
// appears in the cycle after the work ends, in a cycle where busy is already
// low, so the next transaction can be started in that same cycle.
// ----------------------------------------------------------------------------
module tile_grid_rect_collision import tgr_pkg::*; #(
   parameter int MAX_WIDTH    = 64,
   parameter int MAX_HEIGHT   = 64,
   parameter int MAX_VERTICES = 256,
   parameter int TILE_BITS    = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_mode,
   input  wire logic signed [POS_W-1:0]  req_pos_x,
   input  wire logic signed [POS_W-1:0]  req_pos_y,
   input  wire logic [SIZE_W-1:0]        req_rect_w,
   input  wire logic [SIZE_W-1:0]        req_rect_h,
   input  wire logic [TILE_W-1:0]        req_tile_value,
   output logic                          rsp_valid,
   output logic                          rsp_hit_or_ok,
   output logic [TILE_W-1:0]             rsp_tile_read,
   output logic                          rsp_vertex_overflow,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   tgr_cmd_type cmd;
   tgr_sts_type sts;
   logic        csr_we;

   // Registers are plain flops with no side effects, so a write is always
   // accepted; indexes past the register list are dropped.
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // The controller only sequences; all arithmetic and storage sit in the
   // datapath, which reports back through the status bundle.
   tgr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   tgr_dp #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_VERTICES (MAX_VERTICES),
      .TILE_BITS    (TILE_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_rect_w          (req_rect_w),
      .req_rect_h          (req_rect_h),
      .req_tile_value      (req_tile_value),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_hit_or_ok       (rsp_hit_or_ok),
      .rsp_tile_read       (rsp_tile_read),
      .rsp_vertex_overflow (rsp_vertex_overflow)
   );

endmodule
`default_nettype wire

[rtl/tgr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tgr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/tgr_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Truncating divider
// Signed dividend over unsigned divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tgr_div import tgr_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [DVD_W-1:0]  dividend,
   input  wire logic [CDIM_W-1:0]        divisor,
   output logic                          done,
   output logic signed [DVD_W-1:0]       quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [CDIM_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic              neg_ff, neg_in;
   logic [CDIM_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0]  mag;
   logic [CDIM_W:0]   trial;
   logic [CDIM_W:0]   diff;
   logic              ge;

   always_comb begin
      mag   = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
      trial = {rem_ff, quo_ff[DVD_W-1]};
      ge    = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'(DVD_W);
         rem_in  = '0;
         quo_in  = mag;
         neg_in  = dividend[DVD_W-1];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[CDIM_W-1:0] : trial[CDIM_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule
`default_nettype wire

[rtl/tgr_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tile grid datapath
// Configuration registers, operand registers, divider, walk counters, the
// tile memory and the response registers.
// ----------------------------------------------------------------------------
module tgr_dp import tgr_pkg::*; #(
   parameter int MAX_WIDTH    = 64,
   parameter int MAX_HEIGHT   = 64,
   parameter int MAX_VERTICES = 256,
   parameter int TILE_BITS    = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tgr_cmd_type              cmd,
   output tgr_sts_type                   sts,
   input  wire logic signed [POS_W-1:0]  req_pos_x,
   input  wire logic signed [POS_W-1:0]  req_pos_y,
   input  wire logic [SIZE_W-1:0]        req_rect_w,
   input  wire logic [SIZE_W-1:0]        req_rect_h,
   input  wire logic [TILE_W-1:0]        req_tile_value,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata,
   output logic                          rsp_valid,
   output logic                          rsp_hit_or_ok,
   output logic [TILE_W-1:0]             rsp_tile_read,
   output logic                          rsp_vertex_overflow
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = (TILE_BITS < TILE_W) ? TILE_BITS : TILE_W;
   localparam int VCW   = $clog2(MAX_VERTICES);
   localparam logic [10:0] MW_CAP = 11'(MAX_WIDTH);
   localparam logic [10:0] MH_CAP = 11'(MAX_HEIGHT);

   // Configuration.
   logic [CDIM_W-1:0]       cw_ff, ch_ff;
   logic signed [POS_W-1:0] offx_ff, offy_ff;
   logic [MAP_W-1:0]        mapw_ff, maph_ff;

   // Transaction operands and working registers.
   logic signed [POS_W-1:0]  x_ff, y_ff;
   logic [SIZE_W-1:0]        w_ff, h_ff;
   logic [SW-1:0]            val_ff;
   logic signed [CELL_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic [NCNT_W-1:0]        nx_ff, ny_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic signed [DVD_W-1:0]  px_ff, py_ff;
   logic [VCW-1:0]           i_ff, j_ff;
   logic [AW-1:0]            clr_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_hit_ff, rsp_ovf_ff;
   logic [TILE_W-1:0]        rsp_tile_ff;

   logic [CDIM_W-1:0]        cw_eff, ch_eff;
   logic [MAP_W-1:0]         mw_eff, mh_eff;
   logic signed [DVD_W-1:0]  x_ext, y_ext, w_ext, h_ext, cw_ext, ch_ext;
   logic signed [DVD_W-1:0]  x_end, y_end, px_step, py_step;
   logic signed [DVD_W-1:0]  div_a;
   logic [CDIM_W-1:0]        div_b;
   logic                     div_done;
   logic signed [DVD_W-1:0]  div_q;
   logic signed [CELL_W-1:0] q_ext, offx_ext, offy_ext;
   logic signed [CELL_W-1:0] cx_sel, cy_sel;
   logic [14:0]              addr_wide;
   logic [AW-1:0]            cell_addr;
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr;
   logic [SW-1:0]            ram_wdata;
   logic [SW-1:0]            ram_q;

   always_comb begin
      cw_eff = (cw_ff == '0) ? CDIM_W'(1) : cw_ff;
      ch_eff = (ch_ff == '0) ? CDIM_W'(1) : ch_ff;
      mw_eff = (11'(mapw_ff) > MW_CAP) ? MAP_W'(MAX_WIDTH) : mapw_ff;
      mh_eff = (11'(maph_ff) > MH_CAP) ? MAP_W'(MAX_HEIGHT) : maph_ff;

      x_ext  = {{(DVD_W-POS_W){x_ff[POS_W-1]}}, x_ff};
      y_ext  = {{(DVD_W-POS_W){y_ff[POS_W-1]}}, y_ff};
      w_ext  = {{(DVD_W-SIZE_W){1'b0}}, w_ff};
      h_ext  = {{(DVD_W-SIZE_W){1'b0}}, h_ff};
      cw_ext = {{(DVD_W-CDIM_W){1'b0}}, cw_eff};
      ch_ext = {{(DVD_W-CDIM_W){1'b0}}, ch_eff};
      x_end  = x_ext + w_ext - 18'sd1;
      y_end  = y_ext + h_ext - 18'sd1;
      px_step = px_ff + cw_ext;
      py_step = py_ff + ch_ext;

      case (cmd.div_sel)
         DIV_X1: begin div_a = x_ext;  div_b = cw_eff; end
         DIV_Y1: begin div_a = y_ext;  div_b = ch_eff; end
         DIV_X2: begin div_a = x_end;  div_b = cw_eff; end
         DIV_Y2: begin div_a = y_end;  div_b = ch_eff; end
         // Exact ceiling: bias a non-negative span by size - 1.
         DIV_NX: begin
            div_a = (w_ff == '0) ? -18'sd1 : (w_ext + cw_ext - 18'sd2);
            div_b = cw_eff;
         end
         DIV_NY: begin
            div_a = (h_ff == '0) ? -18'sd1 : (h_ext + ch_ext - 18'sd2);
            div_b = ch_eff;
         end
         DIV_PX: begin div_a = px_ff;  div_b = cw_eff; end
         DIV_PY: begin div_a = py_ff;  div_b = ch_eff; end
         default: begin div_a = x_ext; div_b = cw_eff; end
      endcase

      q_ext    = {div_q[DVD_W-1], div_q};
      offx_ext = {{(CELL_W-POS_W){offx_ff[POS_W-1]}}, offx_ff};
      offy_ext = {{(CELL_W-POS_W){offy_ff[POS_W-1]}}, offy_ff};

      cx_sel = (cmd.addr_corner && cmd.corner[0]) ? x2_ff : x1_ff;
      cy_sel = (cmd.addr_corner && cmd.corner[1]) ? y2_ff : y1_ff;
      addr_wide = 15'(cy_sel[MAP_W-1:0]) * 15'(mw_eff) + 15'(cx_sel[MAP_W-1:0]);
      cell_addr = AW'(addr_wide);

      ram_we    = cmd.clear_wr || cmd.wr_cell;
      ram_waddr = cmd.clear_wr ? clr_ff : cell_addr;
      ram_wdata = cmd.clear_wr ? '0 : val_ff;

      sts.div_done   = div_done;
      sts.in_bounds  = in_span(cx_sel, mw_eff) && in_span(cy_sel, mh_eff);
      sts.fast_ok    = in_span(x1_ff, mw_eff) && in_span(y1_ff, mh_eff) &&
                       in_span(x2_ff, mw_eff) && in_span(y2_ff, mh_eff);
      sts.rd_nonzero = ram_q != '0;
      sts.clear_last = clr_ff == AW'(DEPTH - 1);
      sts.vert_ovf   = prod_ff >= PROD_W'(MAX_VERTICES);
      // With no columns there is no vertex to visit, however many rows remain.
      sts.row_end    = ({{(NCNT_W-VCW){1'b0}}, i_ff} >= ny_ff) || (nx_ff == '0);
      sts.col_end    = {{(NCNT_W-VCW){1'b0}}, j_ff} >= nx_ff;
   end

   tgr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   tgr_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cell_addr),
      .rd_data (ram_q)
   );

   // Configuration and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff        <= CDIM_W'(16);
         ch_ff        <= CDIM_W'(16);
         offx_ff      <= '0;
         offy_ff      <= '0;
         mapw_ff      <= MAP_W'(64);
         maph_ff      <= MAP_W'(64);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_CELL_WIDTH:  cw_ff   <= csr_wdata[CDIM_W-1:0];
               CSR_CELL_HEIGHT: ch_ff   <= csr_wdata[CDIM_W-1:0];
               CSR_OFFSET_X:    offx_ff <= $signed(csr_wdata);
               CSR_OFFSET_Y:    offy_ff <= $signed(csr_wdata);
               CSR_MAP_WIDTH:   mapw_ff <= csr_wdata[MAP_W-1:0];
               CSR_MAP_HEIGHT:  maph_ff <= csr_wdata[MAP_W-1:0];
               default: ;
            endcase
         end
         if (cmd.clear_wr) begin
            clr_ff <= clr_ff + AW'(1);
         end
         rsp_valid_ff <= cmd.finish;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= req_pos_x;
         y_ff   <= req_pos_y;
         w_ff   <= req_rect_w;
         h_ff   <= req_rect_h;
         val_ff <= SW'(req_tile_value);
         x1_ff  <= {{(CELL_W-POS_W){req_pos_x[POS_W-1]}}, req_pos_x};
         y1_ff  <= {{(CELL_W-POS_W){req_pos_y[POS_W-1]}}, req_pos_y};
      end
      if (div_done) begin
         case (cmd.div_sel)
            DIV_X1, DIV_PX: x1_ff <= q_ext - offx_ext;
            DIV_Y1, DIV_PY: y1_ff <= q_ext - offy_ext;
            DIV_X2:         x2_ff <= q_ext - offx_ext;
            DIV_Y2:         y2_ff <= q_ext - offy_ext;
            DIV_NX:         nx_ff <= NCNT_W'(div_q + 18'sd1);
            DIV_NY:         ny_ff <= NCNT_W'(div_q + 18'sd1);
            default: ;
         endcase
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(nx_ff) * PROD_W'(ny_ff);
      end
      if (cmd.row_init) begin
         py_ff <= y_ext;
         i_ff  <= '0;
      end else if (cmd.row_next) begin
         py_ff <= (py_step > y_end) ? y_end : py_step;
         i_ff  <= i_ff + VCW'(1);
      end
      if (cmd.col_init) begin
         px_ff <= x_ext;
         j_ff  <= '0;
      end else if (cmd.col_next) begin
         px_ff <= (px_step > x_end) ? x_end : px_step;
         j_ff  <= j_ff + VCW'(1);
      end
      if (cmd.finish) begin
         rsp_hit_ff  <= cmd.res_hit;
         rsp_ovf_ff  <= cmd.res_ovf;
         rsp_tile_ff <= cmd.res_rd ? TILE_W'(ram_q) : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit_or_ok       = rsp_hit_ff;
   assign rsp_tile_read       = rsp_tile_ff;
   assign rsp_vertex_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire

[rtl/tgr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tile grid controller
// Sequences the clearing pass and the four transaction modes.
// ----------------------------------------------------------------------------
module tgr_ctrl import tgr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [1:0]  req_mode,
   input  wire tgr_sts_type sts,
   output tgr_cmd_type      cmd,
   output logic             busy
);

   typedef enum logic [17:0] {
      S_CLEAR  = 18'h00001,
      S_IDLE   = 18'h00002,
      S_WR     = 18'h00004,
      S_RD     = 18'h00008,
      S_RDWAIT = 18'h00010,
      S_FDIV   = 18'h00020,
      S_FBND   = 18'h00040,
      S_FREAD  = 18'h00080,
      S_FCHK   = 18'h00100,
      S_NDIV   = 18'h00200,
      S_MUL    = 18'h00400,
      S_OVCHK  = 18'h00800,
      S_ROW    = 18'h01000,
      S_PYDIV  = 18'h02000,
      S_COL    = 18'h04000,
      S_PXDIV  = 18'h08000,
      S_VREAD  = 18'h10000,
      S_VCHK   = 18'h20000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic       launched_ff, launched_in;

   always_comb begin
      cmd         = '0;
      cmd.corner  = k_ff;
      state_in    = state_ff;
      k_in        = k_ff;
      launched_in = launched_ff;

      // Any divide state starts the divider once and waits for its done.
      if (state_ff == S_FDIV || state_ff == S_NDIV ||
          state_ff == S_PYDIV || state_ff == S_PXDIV) begin
         if (!launched_ff) begin
            cmd.div_start = 1'b1;
            launched_in   = 1'b1;
         end
         if (sts.div_done) begin
            launched_in = 1'b0;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               k_in     = '0;
               case (mode_type'(req_mode))
                  MODE_WRITE: state_in = S_WR;
                  MODE_READ:  state_in = S_RD;
                  MODE_FAST:  state_in = S_FDIV;
                  default:    state_in = S_NDIV;
               endcase
            end
         end
         S_WR: begin
            cmd.finish  = 1'b1;
            cmd.wr_cell = sts.in_bounds;
            cmd.res_hit = sts.in_bounds;
            state_in    = S_IDLE;
         end
         S_RD: begin
            if (sts.in_bounds) begin
               state_in = S_RDWAIT;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_RDWAIT: begin
            cmd.finish = 1'b1;
            cmd.res_rd = 1'b1;
            state_in   = S_IDLE;
         end
         S_FDIV: begin
            case (k_ff)
               2'd0:    cmd.div_sel = DIV_X1;
               2'd1:    cmd.div_sel = DIV_Y1;
               2'd2:    cmd.div_sel = DIV_X2;
               default: cmd.div_sel = DIV_Y2;
            endcase
            if (sts.div_done) begin
               k_in = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  state_in = S_FBND;
               end
            end
         end
         S_FBND: begin
            if (sts.fast_ok) begin
               state_in = S_FREAD;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_FREAD: begin
            cmd.addr_corner = 1'b1;
            state_in        = S_FCHK;
         end
         S_FCHK: begin
            if (sts.rd_nonzero || k_ff == 2'd3) begin
               cmd.finish  = 1'b1;
               cmd.res_hit = sts.rd_nonzero;
               state_in    = S_IDLE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_FREAD;
            end
         end
         S_NDIV: begin
            cmd.div_sel = k_ff[0] ? DIV_NY : DIV_NX;
            if (sts.div_done) begin
               k_in = 2'd1;
               if (k_ff[0]) begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_OVCHK;
         end
         S_OVCHK: begin
            if (sts.vert_ovf) begin
               cmd.finish  = 1'b1;
               cmd.res_ovf = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.row_init = 1'b1;
               state_in     = S_ROW;
            end
         end
         S_ROW: begin
            if (sts.row_end) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_PYDIV;
            end
         end
         S_PYDIV: begin
            cmd.div_sel = DIV_PY;
            if (sts.div_done) begin
               cmd.col_init = 1'b1;
               state_in     = S_COL;
            end
         end
         S_COL: begin
            if (sts.col_end) begin
               cmd.row_next = 1'b1;
               state_in     = S_ROW;
            end else begin
               state_in = S_PXDIV;
            end
         end
         S_PXDIV: begin
            cmd.div_sel = DIV_PX;
            if (sts.div_done) begin
               state_in = S_VREAD;
            end
         end
         S_VREAD: begin
            if (sts.in_bounds) begin
               state_in = S_VCHK;
            end else begin
               cmd.col_next = 1'b1;
               state_in     = S_COL;
            end
         end
         S_VCHK: begin
            if (sts.rd_nonzero) begin
               cmd.finish  = 1'b1;
               cmd.res_hit = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.col_next = 1'b1;
               state_in     = S_COL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         k_ff        <= '0;
         launched_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         k_ff        <= k_in;
         launched_ff <= launched_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule
`default_nettype wire

[rtl/tgr_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tile grid port checker
// Watches the top-level ports for transaction ordering and response coding.
// ----------------------------------------------------------------------------
module tgr_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_hit_or_ok,
   input wire logic [15:0] rsp_tile_read,
   input wire logic        rsp_vertex_overflow
);

   // A taken transaction keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after a transaction was taken");

   // One transaction in flight means responses never come back to back.
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two responses in consecutive cycles");

   // The response is shown only once the block is ready again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   // A skipped full collision reports nothing else.
   a_ovf_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_vertex_overflow) |-> (!rsp_hit_or_ok && rsp_tile_read == 16'd0))
      else $error("overflow response carries other results");

   // A read result never comes with a hit or write acknowledge.
   a_read_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tile_read != 16'd0) |-> !rsp_hit_or_ok)
      else $error("tile read together with hit");

endmodule

bind tile_grid_rect_collision tgr_chk u_tgr_chk (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_hit_or_ok       (rsp_hit_or_ok),
   .rsp_tile_read       (rsp_tile_read),
   .rsp_vertex_overflow (rsp_vertex_overflow)
);
`default_nettype wire

[dv/tile_grid_rect_collision_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile grid rectangle collision testbench
// Drives cell writes, cell reads and both collision queries through the
// start/busy command port, predicts every response from a local model of the
// tile map and compares each strobed response field by field.
// ----------------------------------------------------------------------------
module tile_grid_rect_collision_test;
   import tgr_pkg::*;

   localparam int GRID_W    = 64;
   localparam int GRID_H    = 64;
   localparam int VERT_MAX  = 256;
   // Covers the post-reset clear pass and the longest full collision with
   // a wide margin.
   localparam int STALL_LIMIT = 60000;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_mode;
   logic signed [POS_W-1:0]  req_pos_x;
   logic signed [POS_W-1:0]  req_pos_y;
   logic [SIZE_W-1:0]        req_rect_w;
   logic [SIZE_W-1:0]        req_rect_h;
   logic [TILE_W-1:0]        req_tile_value;
   logic                     rsp_valid;
   logic                     rsp_hit_or_ok;
   logic [TILE_W-1:0]        rsp_tile_read;
   logic                     rsp_vertex_overflow;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   tile_grid_rect_collision u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_rect_w(req_rect_w), .req_rect_h(req_rect_h),
      .req_tile_value(req_tile_value),
      .rsp_valid(rsp_valid), .rsp_hit_or_ok(rsp_hit_or_ok),
      .rsp_tile_read(rsp_tile_read), .rsp_vertex_overflow(rsp_vertex_overflow),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // One predicted response.
   typedef struct {
      logic            hit;
      logic [TILE_W-1:0] tile;
      logic            ovf;
   } answer_type;

   answer_type answers_due[$];
   int         errors;
   int         stall_count;
   logic       accepted_now;
   bit         no_idle;

   // Local copy of the tile map and of the configuration registers.
   logic [TILE_W-1:0] map_cells [GRID_W*GRID_H];
   logic [CDIM_W-1:0] m_cw, m_ch;
   logic signed [POS_W-1:0] m_ox, m_oy;
   logic [MAP_W-1:0]  m_mw, m_mh;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint cw_eff();
      return (m_cw == 0) ? 1 : longint'(m_cw);
   endfunction
   function automatic longint ch_eff();
      return (m_ch == 0) ? 1 : longint'(m_ch);
   endfunction
   function automatic longint mw_eff();
      return (m_mw > GRID_W) ? GRID_W : longint'(m_mw);
   endfunction
   function automatic longint mh_eff();
      return (m_mh > GRID_H) ? GRID_H : longint'(m_mh);
   endfunction

   function automatic bit on_map(longint cx, longint cy);
      return cx >= 0 && cx < mw_eff() && cy >= 0 && cy < mh_eff();
   endfunction

   function automatic logic [TILE_W-1:0] tile_at(longint cx, longint cy);
      if (!on_map(cx, cy)) return '0;
      return map_cells[cy * mw_eff() + cx];
   endfunction

   // Division toward zero, and the exact ceiling, for a positive divisor.
   function automatic longint div_trunc(longint a, longint b);
      return (a >= 0) ? a / b : -((-a) / b);
   endfunction
   function automatic longint div_ceil(longint a, longint b);
      return (a >= 0) ? (a + b - 1) / b : -((-a) / b);
   endfunction

   function automatic bit pixel_hits(longint px, longint py);
      longint cx, cy;
      cx = div_trunc(px, cw_eff()) - longint'(m_ox);
      cy = div_trunc(py, ch_eff()) - longint'(m_oy);
      return tile_at(cx, cy) != 0;
   endfunction

   // Computes the response of one command and applies its effect on the map.
   function automatic answer_type collide_or_access(mode_type mode, longint x, longint y,
                                                    longint w, longint h,
                                                    logic [TILE_W-1:0] val);
      answer_type a;
      longint cw, ch, x1, y1, x2, y2, wm, hm, nx, ny, px, py;
      a.hit = 1'b0;
      a.tile = '0;
      a.ovf = 1'b0;
      cw = cw_eff();
      ch = ch_eff();
      case (mode)
         MODE_WRITE: begin
            if (on_map(x, y)) begin
               map_cells[y * mw_eff() + x] = val;
               a.hit = 1'b1;
            end
         end
         MODE_READ: begin
            a.tile = tile_at(x, y);
         end
         MODE_FAST: begin
            x1 = div_trunc(x, cw) - longint'(m_ox);
            y1 = div_trunc(y, ch) - longint'(m_oy);
            x2 = div_trunc(x + w - 1, cw) - longint'(m_ox);
            y2 = div_trunc(y + h - 1, ch) - longint'(m_oy);
            if (on_map(x1, y1) && on_map(x2, y2))
               a.hit = (tile_at(x1, y1) != 0) || (tile_at(x2, y1) != 0) ||
                       (tile_at(x1, y2) != 0) || (tile_at(x2, y2) != 0);
         end
         default: begin
            wm = w - 1;
            hm = h - 1;
            nx = div_ceil(wm, cw) + 1;
            ny = div_ceil(hm, ch) + 1;
            if (nx * ny < VERT_MAX) begin
               py = y;
               for (longint i = 0; i < ny && !a.hit; i++) begin
                  px = x;
                  for (longint j = 0; j < nx && !a.hit; j++) begin
                     if (pixel_hits(px, py)) a.hit = 1'b1;
                     px = (px + cw > x + wm) ? x + wm : px + cw;
                  end
                  py = (py + ch > y + hm) ? y + hm : py + ch;
               end
            end else begin
               a.ovf = 1'b1;
            end
         end
      endcase
      return a;
   endfunction

   // Sends one command transaction. The start line is left high after the
   // accepting edge so that a following command can go back to back; it is
   // lowered either by the next idle gap or by stop_commands.
   task automatic send_command(mode_type mode, logic signed [POS_W-1:0] x,
                               logic signed [POS_W-1:0] y, logic [SIZE_W-1:0] w,
                               logic [SIZE_W-1:0] h, logic [TILE_W-1:0] val);
      if (!no_idle && $urandom_range(99) < 31) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 31);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_pos_x <= x;
      req_pos_y <= y;
      req_rect_w <= w;
      req_rect_h <= h;
      req_tile_value <= val;
      // busy read here still holds its value from before the edge.
      do @(posedge clock); while (busy);
      answers_due.push_back(collide_or_access(mode, longint'(x), longint'(y),
                                              longint'(w), longint'(h), val));
   endtask

   task automatic stop_commands();
      start <= 1'b0;
   endtask

   // Lowers start and waits until every response has come back.
   task automatic drain();
      stop_commands();
      while (answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CELL_WIDTH:  m_cw = data[CDIM_W-1:0];
         CSR_CELL_HEIGHT: m_ch = data[CDIM_W-1:0];
         CSR_OFFSET_X:    m_ox = data;
         CSR_OFFSET_Y:    m_oy = data;
         CSR_MAP_WIDTH:   m_mw = data[MAP_W-1:0];
         CSR_MAP_HEIGHT:  m_mh = data[MAP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(int cw, int ch, int ox, int oy, int mw, int mh);
      drain();
      write_csr(CSR_CELL_WIDTH, cw[15:0]);
      write_csr(CSR_CELL_HEIGHT, ch[15:0]);
      write_csr(CSR_OFFSET_X, ox[15:0]);
      write_csr(CSR_OFFSET_Y, oy[15:0]);
      write_csr(CSR_MAP_WIDTH, mw[15:0]);
      write_csr(CSR_MAP_HEIGHT, mh[15:0]);
   endtask

   function automatic logic signed [POS_W-1:0] clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Cell accesses at the edges of the map and just outside it, including
   // negative indexes, the extreme positions and the extreme tile ids.
   task automatic test_cell_access();
      send_command(MODE_WRITE, 0, 0, 0, 0, 16'hffff);
      send_command(MODE_WRITE, 63, 63, 0, 0, 16'h0001);
      send_command(MODE_WRITE, 63, 0, 0, 0, 16'h8000);
      send_command(MODE_WRITE, -1, 0, 0, 0, 16'h1234);
      send_command(MODE_WRITE, 0, -1, 0, 0, 16'h1234);
      send_command(MODE_WRITE, 64, 0, 0, 0, 16'h1234);
      send_command(MODE_WRITE, 16'sh7fff, 16'sh7fff, 0, 0, 16'h5555);
      send_command(MODE_WRITE, 16'sh8000, 16'sh8000, 0, 0, 16'haaaa);
      send_command(MODE_READ, 0, 0, 0, 0, 0);
      send_command(MODE_READ, 63, 63, 0, 0, 0);
      send_command(MODE_READ, 63, 0, 0, 0, 0);
      send_command(MODE_READ, -1, -1, 0, 0, 0);
      send_command(MODE_READ, 5, 5, 0, 0, 0);
   endtask

   // Corner queries: an occupied corner, a corner off the map, and a
   // negative pixel that truncates toward zero into cell 0.
   task automatic test_fast_collision();
      send_command(MODE_FAST, 0, 0, 1, 1, 0);
      send_command(MODE_FAST, -15, -15, 16, 16, 0);
      send_command(MODE_FAST, 1000, 1000, 24, 24, 0);
      send_command(MODE_FAST, -40, 0, 8, 8, 0);
      send_command(MODE_FAST, 0, 0, 15'h7fff, 15'h7fff, 0);
   endtask

   // Full walks: zero size, one pixel, a walk that ends on a far corner,
   // and sizes large enough to overflow the vertex budget.
   task automatic test_full_collision();
      send_command(MODE_FULL, 0, 0, 0, 0, 0);
      send_command(MODE_FULL, 0, 0, 1, 1, 0);
      send_command(MODE_FULL, 100, 100, 40, 40, 0);
      send_command(MODE_FULL, 980, 980, 40, 40, 0);
      send_command(MODE_FULL, 0, 0, 15'h7fff, 15'h7fff, 0);
      send_command(MODE_FULL, 0, 0, 15'd256, 15'd240, 0);
   endtask

   // One random phase. Most commands aim at the map with small rectangles;
   // a tenth carry fully random fields so that every bit is exercised.
   task automatic random_phase(int count);
      int pick;
      longint cw, ch, span_x, span_y;
      mode_type mode;
      logic signed [POS_W-1:0] x, y;
      logic [SIZE_W-1:0] w, h;
      logic [TILE_W-1:0] val;
      cw = cw_eff();
      ch = ch_eff();
      span_x = (mw_eff() + 4) * cw;
      span_y = (mh_eff() + 4) * ch;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         mode = (pick < 25) ? MODE_WRITE : (pick < 45) ? MODE_READ :
                (pick < 70) ? MODE_FAST : MODE_FULL;
         val = ($urandom_range(99) < 30) ? '0 : TILE_W'($urandom);
         if ($urandom_range(9) == 0) begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
            w = SIZE_W'($urandom);
            h = SIZE_W'($urandom);
            val = TILE_W'($urandom);
         end else if (mode == MODE_WRITE || mode == MODE_READ) begin
            x = POS_W'(int'($urandom_range(32'(mw_eff() + 6))) - 3);
            y = POS_W'(int'($urandom_range(32'(mh_eff() + 6))) - 3);
            w = SIZE_W'($urandom);
            h = SIZE_W'($urandom);
         end else begin
            x = clip16((longint'(m_ox) - 2) * cw +
                       longint'($urandom_range(32'(span_x))));
            y = clip16((longint'(m_oy) - 2) * ch +
                       longint'($urandom_range(32'(span_y))));
            w = (cw * 5 > 32767) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(32'(cw * 5)));
            h = (ch * 5 > 32767) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(32'(ch * 5)));
         end
         send_command(mode, x, y, w, h, val);
      end
   endtask

   // Random phases over a range of geometries: reset values, zero and
   // maximum cell sizes, extreme offsets, an empty map, oversized map
   // registers that saturate, and a small map.
   task automatic test_geometry_sweep();
      set_geometry(16, 16, 0, 0, 64, 64);
      random_phase(260);
      set_geometry(1, 1, 0, 0, 64, 64);
      random_phase(180);
      set_geometry(0, 0, 3, -2, 20, 30);
      random_phase(180);
      set_geometry(2047, 1024, -1, 1, 127, 127);
      random_phase(160);
      set_geometry(8, 4, 0, 0, 0, 0);
      random_phase(120);
      set_geometry(5, 7, -32768, 32767, 64, 64);
      random_phase(100);
      no_idle = 1'b1;
      set_geometry(3, 9, 2, 1, 5, 3);
      random_phase(200);
      no_idle = 1'b0;
      set_geometry(32, 16, -4, -4, 40, 63);
      random_phase(200);
      set_geometry(16, 16, 0, 0, 64, 64);
      random_phase(200);
   endtask

   // Each strobed response is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            errors++;
            $display("%0t: response with none expected: hit %0b tile %h ovf %0b",
                     $time, rsp_hit_or_ok, rsp_tile_read, rsp_vertex_overflow);
         end else begin
            answer_type a;
            a = answers_due.pop_front();
            if (rsp_hit_or_ok !== a.hit) begin
               errors++;
               $display("%0t: hit_or_ok expected %0b actual %0b", $time, a.hit,
                        rsp_hit_or_ok);
            end
            if (rsp_tile_read !== a.tile) begin
               errors++;
               $display("%0t: tile_read expected %h actual %h", $time, a.tile,
                        rsp_tile_read);
            end
            if (rsp_vertex_overflow !== a.ovf) begin
               errors++;
               $display("%0t: vertex_overflow expected %0b actual %0b", $time, a.ovf,
                        rsp_vertex_overflow);
            end
         end
      end
   end

   // Watchdog: counts cycles in which no transaction moves in either
   // direction.
   always @(posedge clock) begin
      accepted_now = start && !busy;
      if (reset || accepted_now || rsp_valid || csr_valid) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      errors = 0;
      stall_count = 0;
      no_idle = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_WRITE;
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_rect_w <= '0;
      req_rect_h <= '0;
      req_tile_value <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_CELL_WIDTH;
      csr_wdata <= '0;
      foreach (map_cells[i]) map_cells[i] = '0;
      m_cw = 16;
      m_ch = 16;
      m_ox = 0;
      m_oy = 0;
      m_mw = 64;
      m_mh = 64;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cell_access();
      test_fast_collision();
      test_full_collision();
      test_geometry_sweep();
      drain();
      repeat (20) @(posedge clock);

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
